/* rtl/assert_macros.svh */
// assertion macros used by the top-level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold at every clock edge out of reset
`define ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error(msg);

// same-cycle implication
`define ASSERT_IMPLIES(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/ipv4f_pkg.sv */
// types and constants of the ipv4 icmp reply frame filter
`default_nettype none

package ipv4f_pkg;

    localparam int POS_W = 12;
    localparam logic [POS_W-1:0] MAX_FRAME_BYTES = POS_W'(2048);

    localparam logic [POS_W-1:0] POS_ETH_HI   = POS_W'(12);
    localparam logic [POS_W-1:0] POS_ETH_LO   = POS_W'(13);
    localparam logic [POS_W-1:0] POS_IP_START = POS_W'(14);
    localparam logic [POS_W-1:0] POS_TLEN_HI  = POS_W'(16);
    localparam logic [POS_W-1:0] POS_TLEN_LO  = POS_W'(17);
    localparam logic [POS_W-1:0] POS_PROTO    = POS_W'(23);
    localparam logic [POS_W-1:0] POS_DEST_LO  = POS_W'(30);
    localparam logic [POS_W-1:0] POS_DEST_HI  = POS_W'(33);
    localparam logic [POS_W-1:0] MIN_FRAME    = POS_W'(34);

    localparam logic [5:0]  MIN_HDR_LEN    = 6'd20;
    localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
    localparam logic [3:0]  IP_VERSION_4   = 4'd4;
    localparam logic [7:0]  PROTO_ICMP     = 8'd1;
    localparam logic [16:0] SUM_GOOD       = 17'h0FFFF;
    localparam logic [7:0]  ICMP_ECHO_REPLY = 8'd0;

    localparam logic [31:0] LOCAL_ADDR_RESET = 32'h0A00020F;

    localparam int REC_DEPTH = 2;
    localparam int REC_PTR_W = $clog2(REC_DEPTH);
    localparam int REC_CNT_W = $clog2(REC_DEPTH + 1);

    localparam int RES_DEPTH = 2;
    localparam int RES_PTR_W = $clog2(RES_DEPTH);
    localparam int RES_CNT_W = $clog2(RES_DEPTH + 1);

    typedef enum logic [3:0] {
        CAUSE_OK        = 4'd0,
        CAUSE_SHORT     = 4'd1,
        CAUSE_ETHERTYPE = 4'd2,
        CAUSE_VERSION   = 4'd3,
        CAUSE_HDR_LEN   = 4'd4,
        CAUSE_TOTAL_LEN = 4'd5,
        CAUSE_DEST      = 4'd6,
        CAUSE_PROTO     = 4'd7,
        CAUSE_CHECKSUM  = 4'd8,
        CAUSE_ICMP_TYPE = 4'd9
    } t_cause;

    typedef struct packed {
        logic [POS_W-1:0] frame_len;
        logic [15:0]      ethertype;
        logic [7:0]       ver_ihl;
        logic [15:0]      total_len;
        logic [31:0]      dest_addr;
        logic [7:0]       protocol;
        logic [16:0]      hdr_sum;
        logic [7:0]       icmp_type;
        logic             icmp_seen;
    } t_frame_rec;

    typedef struct packed {
        logic       valid;
        t_frame_rec rec;
    } t_rec_beat;

    typedef struct packed {
        logic   accepted;
        t_cause cause;
    } t_result;

endpackage

`default_nettype wire

/* rtl/ipv4f_front.sv */
// front end: byte parser that captures header fields and the running header sum
`default_nettype none

module ipv4f_front (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_push,
    input  logic [7:0]             i_frame_byte,
    input  logic                   i_last_byte,
    input  logic                   i_rec_full,
    output logic                   o_full,
    output ipv4f_pkg::t_rec_beat   o_rec
);
    import ipv4f_pkg::*;

    logic [POS_W-1:0] r_pos,       n_pos;
    logic [15:0]      r_ethertype, n_ethertype;
    logic [7:0]       r_ver_ihl,   n_ver_ihl;
    logic [15:0]      r_total_len, n_total_len;
    logic [31:0]      r_dest,      n_dest;
    logic [7:0]       r_proto,     n_proto;
    logic [16:0]      r_sum,       n_sum;
    logic [7:0]       r_icmp_type, n_icmp_type;
    logic             r_icmp_seen, n_icmp_seen;

    logic             w_accept;
    logic             w_take;
    logic [7:0]       w_ver_ihl_eff;
    logic [5:0]       w_hlen;
    logic [POS_W-1:0] w_hdr_end;
    logic [15:0]      w_add;
    logic [17:0]      w_sum_raw;
    logic [16:0]      w_sum_fold;

    assign w_accept = i_push && !i_rec_full;
    assign o_full   = i_rec_full;
    assign w_take   = r_pos < MAX_FRAME_BYTES;

    // header length uses the byte being taken when it is the version byte
    assign w_ver_ihl_eff = (r_pos == POS_IP_START) ? i_frame_byte : r_ver_ihl;
    assign w_hlen        = {w_ver_ihl_eff[3:0], 2'b00};
    assign w_hdr_end     = POS_IP_START + POS_W'(w_hlen);

    // odd offsets from the header start carry the low byte of a word
    assign w_add      = r_pos[0] ? {8'h00, i_frame_byte} : {i_frame_byte, 8'h00};
    assign w_sum_raw  = 18'(r_sum) + 18'(w_add);
    assign w_sum_fold = 17'(w_sum_raw[15:0]) + 17'(w_sum_raw[17:16]);

    always_comb begin
        n_pos       = r_pos;
        n_ethertype = r_ethertype;
        n_ver_ihl   = r_ver_ihl;
        n_total_len = r_total_len;
        n_dest      = r_dest;
        n_proto     = r_proto;
        n_sum       = r_sum;
        n_icmp_type = r_icmp_type;
        n_icmp_seen = r_icmp_seen;
        if (w_accept && w_take) begin
            if (r_pos == POS_ETH_HI || r_pos == POS_ETH_LO) begin
                n_ethertype = {r_ethertype[7:0], i_frame_byte};
            end
            if (r_pos == POS_IP_START) begin
                n_ver_ihl = i_frame_byte;
            end
            if (r_pos == POS_TLEN_HI || r_pos == POS_TLEN_LO) begin
                n_total_len = {r_total_len[7:0], i_frame_byte};
            end
            if (r_pos == POS_PROTO) begin
                n_proto = i_frame_byte;
            end
            if (r_pos >= POS_DEST_LO && r_pos <= POS_DEST_HI) begin
                n_dest = {r_dest[23:0], i_frame_byte};
            end
            if (r_pos >= POS_IP_START && r_pos < w_hdr_end) begin
                n_sum = w_sum_fold;
            end
            if (r_pos > POS_IP_START && r_pos == w_hdr_end) begin
                n_icmp_type = i_frame_byte;
                n_icmp_seen = 1'b1;
            end
            n_pos = r_pos + POS_W'(1);
        end
    end

    always_comb begin
        o_rec.valid         = w_accept && i_last_byte;
        o_rec.rec.frame_len = n_pos;
        o_rec.rec.ethertype = n_ethertype;
        o_rec.rec.ver_ihl   = n_ver_ihl;
        o_rec.rec.total_len = n_total_len;
        o_rec.rec.dest_addr = n_dest;
        o_rec.rec.protocol  = n_proto;
        o_rec.rec.hdr_sum   = n_sum;
        o_rec.rec.icmp_type = n_icmp_type;
        o_rec.rec.icmp_seen = n_icmp_seen;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (w_accept && i_last_byte)) begin
            r_pos       <= '0;
            r_ethertype <= '0;
            r_ver_ihl   <= '0;
            r_total_len <= '0;
            r_dest      <= '0;
            r_proto     <= '0;
            r_sum       <= '0;
            r_icmp_type <= '0;
            r_icmp_seen <= 1'b0;
        end else begin
            r_pos       <= n_pos;
            r_ethertype <= n_ethertype;
            r_ver_ihl   <= n_ver_ihl;
            r_total_len <= n_total_len;
            r_dest      <= n_dest;
            r_proto     <= n_proto;
            r_sum       <= n_sum;
            r_icmp_type <= n_icmp_type;
            r_icmp_seen <= n_icmp_seen;
        end
    end

endmodule

`default_nettype wire

/* rtl/ipv4f_rec_queue.sv */
// short queue of captured frame records between front and back end
`default_nettype none

module ipv4f_rec_queue (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  ipv4f_pkg::t_rec_beat   i_push,
    output logic                   o_full,
    output logic                   o_valid,
    output ipv4f_pkg::t_frame_rec  o_head,
    input  logic                   i_pop
);
    import ipv4f_pkg::*;

    t_frame_rec           r_mem [REC_DEPTH];
    logic [REC_PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [REC_PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [REC_CNT_W-1:0] r_count,  n_count;
    logic                 w_wr;
    logic                 w_rd;

    assign o_full  = r_count == REC_CNT_W'(REC_DEPTH);
    assign o_valid = r_count != '0;
    assign o_head  = r_mem[r_rd_ptr];
    assign w_wr    = i_push.valid && !o_full;
    assign w_rd    = i_pop && o_valid;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (w_wr) begin
            n_wr_ptr = (r_wr_ptr == REC_PTR_W'(REC_DEPTH - 1)) ? '0 : r_wr_ptr + REC_PTR_W'(1);
        end
        if (w_rd) begin
            n_rd_ptr = (r_rd_ptr == REC_PTR_W'(REC_DEPTH - 1)) ? '0 : r_rd_ptr + REC_PTR_W'(1);
        end
        if (w_wr && !w_rd) begin
            n_count = r_count + REC_CNT_W'(1);
        end else if (w_rd && !w_wr) begin
            n_count = r_count - REC_CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wr_ptr] <= i_push.rec;
        end
    end

endmodule

`default_nettype wire

/* rtl/ipv4f_back.sv */
// back end: ordered header checks, local address register and result queue
`default_nettype none

module ipv4f_back (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_we,
    input  logic [31:0]            i_cfg_wdata,
    input  logic                   i_rec_valid,
    input  ipv4f_pkg::t_frame_rec  i_rec,
    output logic                   o_rec_pop,
    output logic                   o_empty,
    output ipv4f_pkg::t_result     o_result,
    input  logic                   i_pop
);
    import ipv4f_pkg::*;

    logic [31:0]          r_local_addr;
    t_result              r_mem [RES_DEPTH];
    logic [RES_PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [RES_PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [RES_CNT_W-1:0] r_count,  n_count;

    logic       w_full;
    logic       w_wr;
    logic       w_rd;
    logic [5:0] w_hlen;
    t_cause     w_cause;
    t_result    w_result;

    assign w_hlen = {i_rec.ver_ihl[3:0], 2'b00};

    always_comb begin
        if (i_rec.frame_len < MIN_FRAME) begin
            w_cause = CAUSE_SHORT;
        end else if (i_rec.ethertype != ETHERTYPE_IPV4) begin
            w_cause = CAUSE_ETHERTYPE;
        end else if (i_rec.ver_ihl[7:4] != IP_VERSION_4) begin
            w_cause = CAUSE_VERSION;
        end else if (w_hlen < MIN_HDR_LEN
                     || i_rec.frame_len < POS_IP_START + POS_W'(w_hlen)) begin
            w_cause = CAUSE_HDR_LEN;
        end else if (i_rec.total_len < 16'(w_hlen)
                     || i_rec.total_len > 16'(i_rec.frame_len - POS_IP_START)) begin
            w_cause = CAUSE_TOTAL_LEN;
        end else if (i_rec.dest_addr != r_local_addr) begin
            w_cause = CAUSE_DEST;
        end else if (i_rec.protocol != PROTO_ICMP) begin
            w_cause = CAUSE_PROTO;
        end else if (i_rec.hdr_sum != SUM_GOOD) begin
            w_cause = CAUSE_CHECKSUM;
        end else if (!i_rec.icmp_seen || i_rec.icmp_type != ICMP_ECHO_REPLY) begin
            w_cause = CAUSE_ICMP_TYPE;
        end else begin
            w_cause = CAUSE_OK;
        end
        w_result.accepted = w_cause == CAUSE_OK;
        w_result.cause    = w_cause;
    end

    assign w_full    = r_count == RES_CNT_W'(RES_DEPTH);
    assign o_empty   = r_count == '0;
    assign o_result  = r_mem[r_rd_ptr];
    assign w_wr      = i_rec_valid && !w_full;
    assign w_rd      = i_pop && !o_empty;
    assign o_rec_pop = w_wr;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (w_wr) begin
            n_wr_ptr = (r_wr_ptr == RES_PTR_W'(RES_DEPTH - 1)) ? '0 : r_wr_ptr + RES_PTR_W'(1);
        end
        if (w_rd) begin
            n_rd_ptr = (r_rd_ptr == RES_PTR_W'(RES_DEPTH - 1)) ? '0 : r_rd_ptr + RES_PTR_W'(1);
        end
        if (w_wr && !w_rd) begin
            n_count = r_count + RES_CNT_W'(1);
        end else if (w_rd && !w_wr) begin
            n_count = r_count - RES_CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_local_addr <= LOCAL_ADDR_RESET;
            r_wr_ptr     <= '0;
            r_rd_ptr     <= '0;
            r_count      <= '0;
        end else begin
            if (i_cfg_we) begin
                r_local_addr <= i_cfg_wdata;
            end
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wr_ptr] <= w_result;
        end
    end

endmodule

`default_nettype wire

/* rtl/ipv4_icmp_reply_frame_filter.sv */
// Receive-side IPv4 ICMP echo-reply filter. Frame bytes enter one per clock
// while full is low, through push/full, starting at the destination MAC,
// with i_last_byte on the final beat; full rises only when the two-entry
// record queue between the parser and the checker is full, so a steady byte
// stream is never stalled while results are drained. Each frame yields one
// verdict (o_accepted, o_reject_cause naming the first failing check): its
// record is registered in the record queue, then moved by the checker into a
// two-entry result queue whose head drives the result ports until popped.
// Bytes past 2048 are ignored for length purposes. The local address register
// may only be written while no frame is in flight and no verdict is pending.
`default_nettype none

`include "assert_macros.svh"

module ipv4_icmp_reply_frame_filter (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic [7:0]  i_frame_byte,
    input  logic        i_last_byte,
    output logic        empty,
    input  logic        pop,
    output logic        o_accepted,
    output logic [3:0]  o_reject_cause,
    input  logic        i_cfg_we,
    input  logic [31:0] i_cfg_wdata
);
    import ipv4f_pkg::*;

    t_rec_beat  w_rec_push;
    logic       w_rec_full;
    logic       w_rec_valid;
    t_frame_rec w_rec_head;
    logic       w_rec_pop;
    t_result    w_result;

    ipv4f_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .i_frame_byte (i_frame_byte),
        .i_last_byte  (i_last_byte),
        .i_rec_full   (w_rec_full),
        .o_full       (full),
        .o_rec        (w_rec_push)
    );

    ipv4f_rec_queue u_rec_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_rec_push),
        .o_full  (w_rec_full),
        .o_valid (w_rec_valid),
        .o_head  (w_rec_head),
        .i_pop   (w_rec_pop)
    );

    ipv4f_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_rec_valid (w_rec_valid),
        .i_rec       (w_rec_head),
        .o_rec_pop   (w_rec_pop),
        .o_empty     (empty),
        .o_result    (w_result),
        .i_pop       (pop)
    );

    assign o_accepted     = w_result.accepted;
    assign o_reject_cause = 4'(w_result.cause);

    `ASSERT_IMPLIES(a_accept_matches_cause, !empty,
        o_accepted == (o_reject_cause == 4'(CAUSE_OK)), "verdict flag disagrees with cause")
    `ASSERT_IMPLIES(a_cause_in_range, !empty,
        o_reject_cause <= 4'(CAUSE_ICMP_TYPE), "reject cause out of range")
    `ASSERT_NEXT(a_last_beat_queued, push && !full && i_last_byte,
        w_rec_valid, "last byte taken but no record queued")

endmodule

`default_nettype wire

/* tb/sv/tb_ipv4_icmp_reply_frame_filter.sv */
// testbench for the ipv4 icmp reply frame filter: directed and random frames checked per verdict
`timescale 1ns / 1ps

module tb_ipv4_icmp_reply_frame_filter;
    import ipv4f_pkg::*;

    localparam int DRAIN_CYCLES = 8;
    localparam int PHASE_BYTES  = 120;
    localparam int PHASE_FRAMES = 2;
    localparam int NUM_DIRECTED = 22;

    typedef enum logic [3:0] {
        FK_GOOD,
        FK_ETHERTYPE,
        FK_VERSION,
        FK_DEST,
        FK_PROTO,
        FK_CHECKSUM,
        FK_ICMP_TYPE,
        FK_NOISE
    } t_frame_kind;

    typedef struct packed {
        t_frame_kind kind;
        logic [3:0]  ihl;
        int          payload;
        int          tlen;
        int          cut;
        logic [31:0] val;
        logic        known;
        t_cause      want;
    } t_frame_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        push = 1'b0;
    logic        full;
    logic [7:0]  i_frame_byte = 8'h00;
    logic        i_last_byte = 1'b0;
    logic        empty;
    logic        pop = 1'b0;
    logic        o_accepted;
    logic [3:0]  o_reject_cause;
    logic        i_cfg_we = 1'b0;
    logic [31:0] i_cfg_wdata = 32'h0;

    ipv4_icmp_reply_frame_filter dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .push           (push),
        .full           (full),
        .i_frame_byte   (i_frame_byte),
        .i_last_byte    (i_last_byte),
        .empty          (empty),
        .pop            (pop),
        .o_accepted     (o_accepted),
        .o_reject_cause (o_reject_cause),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    initial begin
        #10_000_000;
        $display("Test completed with failures");
        $finish;
    end

    // frame tracking state
    logic [POS_W-1:0] pos_cnt = '0;
    logic [15:0]      eth_type = '0;
    logic [7:0]       ver_ihl = '0;
    logic [15:0]      tot_len = '0;
    logic [31:0]      dst_addr = '0;
    logic [7:0]       proto = '0;
    logic [16:0]      hsum = '0;
    logic [7:0]       icmp_type = '0;
    logic             icmp_seen = 1'b0;
    logic [31:0]      own_addr = LOCAL_ADDR_RESET;

    t_result    verdict_q [$];
    logic [7:0] frame_bytes [$];

    int sender_idle_pct = 0;
    int recv_stall_pct = 0;
    int mismatch_count = 0;
    int frames_sent = 0;
    int bytes_sent = 0;
    int verdicts_checked = 0;
    int frames_passed = 0;

    t_frame_row directed_rows [NUM_DIRECTED] = '{
        '{FK_NOISE,     4'd5,  1,  -1,    -1, 32'h0,         1'b1, CAUSE_SHORT},
        '{FK_GOOD,      4'd5,  8,  -1,    33, 32'h0,         1'b1, CAUSE_SHORT},
        '{FK_GOOD,      4'd5,  8,  -1,    34, 32'h0,         1'b0, CAUSE_OK},
        '{FK_ETHERTYPE, 4'd5,  8,  -1,    -1, 32'hFFFF,      1'b1, CAUSE_ETHERTYPE},
        '{FK_ETHERTYPE, 4'd5,  8,  -1,    -1, 32'h0000,      1'b1, CAUSE_ETHERTYPE},
        '{FK_VERSION,   4'd5,  8,  -1,    -1, 32'hF,         1'b1, CAUSE_VERSION},
        '{FK_VERSION,   4'd5,  8,  -1,    -1, 32'h0,         1'b1, CAUSE_VERSION},
        '{FK_GOOD,      4'd0,  8,  -1,    -1, 32'h0,         1'b1, CAUSE_HDR_LEN},
        '{FK_GOOD,      4'd4,  8,  -1,    -1, 32'h0,         1'b1, CAUSE_HDR_LEN},
        '{FK_GOOD,      4'd15, 8,  -1,    73, 32'h0,         1'b1, CAUSE_HDR_LEN},
        '{FK_GOOD,      4'd5,  8,  0,     -1, 32'h0,         1'b1, CAUSE_TOTAL_LEN},
        '{FK_GOOD,      4'd5,  8,  65535, -1, 32'h0,         1'b1, CAUSE_TOTAL_LEN},
        '{FK_GOOD,      4'd5,  8,  20,    -1, 32'h0,         1'b0, CAUSE_OK},
        '{FK_DEST,      4'd5,  8,  -1,    -1, 32'h0,         1'b1, CAUSE_DEST},
        '{FK_DEST,      4'd5,  8,  -1,    -1, 32'hFFFF_FFFF, 1'b1, CAUSE_DEST},
        '{FK_PROTO,     4'd5,  8,  -1,    -1, 32'hFF,        1'b1, CAUSE_PROTO},
        '{FK_PROTO,     4'd5,  8,  -1,    -1, 32'h0,         1'b1, CAUSE_PROTO},
        '{FK_CHECKSUM,  4'd5,  8,  -1,    -1, 32'h8000,      1'b1, CAUSE_CHECKSUM},
        '{FK_ICMP_TYPE, 4'd5,  8,  -1,    -1, 32'hFF,        1'b1, CAUSE_ICMP_TYPE},
        '{FK_GOOD,      4'd5,  8,  20,    34, 32'h0,         1'b1, CAUSE_ICMP_TYPE},
        '{FK_GOOD,      4'd5,  1,  -1,    -1, 32'h0,         1'b1, CAUSE_OK},
        '{FK_GOOD,      4'd15, 24, -1,    -1, 32'h0,         1'b1, CAUSE_OK}
    };

    function automatic t_cause frame_verdict(input int len);
        int hl;
        hl = int'(ver_ihl[3:0]) * 4;
        if (len < int'(MIN_FRAME))
            return CAUSE_SHORT;
        if (eth_type != ETHERTYPE_IPV4)
            return CAUSE_ETHERTYPE;
        if (ver_ihl[7:4] != IP_VERSION_4)
            return CAUSE_VERSION;
        if (hl < int'(MIN_HDR_LEN) || len < int'(POS_IP_START) + hl)
            return CAUSE_HDR_LEN;
        if (int'(tot_len) < hl || int'(tot_len) > len - int'(POS_IP_START))
            return CAUSE_TOTAL_LEN;
        if (dst_addr != own_addr)
            return CAUSE_DEST;
        if (proto != PROTO_ICMP)
            return CAUSE_PROTO;
        if (hsum != SUM_GOOD)
            return CAUSE_CHECKSUM;
        if (!icmp_seen || icmp_type != ICMP_ECHO_REPLY)
            return CAUSE_ICMP_TYPE;
        return CAUSE_OK;
    endfunction

    task automatic absorb_byte(input logic [7:0] b, input logic last,
                               output logic done, output t_cause cause);
        int p;
        int hl;
        int add;
        int s;
        done = 1'b0;
        cause = CAUSE_OK;
        if (pos_cnt < MAX_FRAME_BYTES) begin
            p = int'(pos_cnt);
            if (p == 12 || p == 13)
                eth_type = {eth_type[7:0], b};
            if (p == 14)
                ver_ihl = b;
            if (p == 16 || p == 17)
                tot_len = {tot_len[7:0], b};
            if (p == 23)
                proto = b;
            if (p >= 30 && p <= 33)
                dst_addr = {dst_addr[23:0], b};
            hl = int'(ver_ihl[3:0]) * 4;
            if (p >= 14 && p < 14 + hl) begin
                add = ((p - 14) % 2 == 1) ? int'(b) : (int'(b) << 8);
                s = int'(hsum) + add;
                hsum = 17'((s & 'hFFFF) + (s >> 16));
            end
            if (p > 14 && p == 14 + hl) begin
                icmp_type = b;
                icmp_seen = 1'b1;
            end
            pos_cnt = pos_cnt + POS_W'(1);
        end
        if (last) begin
            done = 1'b1;
            cause = frame_verdict(int'(pos_cnt));
            pos_cnt = '0;
            eth_type = '0;
            ver_ihl = '0;
            tot_len = '0;
            dst_addr = '0;
            proto = '0;
            hsum = '0;
            icmp_type = '0;
            icmp_seen = 1'b0;
        end
    endtask

    task automatic build_frame(input t_frame_row r);
        logic [7:0]  hdr [60];
        logic [15:0] tl16;
        logic [15:0] ck;
        logic [15:0] etype;
        logic [31:0] dst;
        int hl;
        int hb;
        int s;
        frame_bytes.delete();
        if (r.kind == FK_NOISE) begin
            for (int i = 0; i < r.payload; i++)
                frame_bytes.push_back(8'($urandom));
        end else begin
            hl = int'(r.ihl) * 4;
            hb = (hl < 20) ? 20 : hl;
            tl16 = (r.tlen < 0) ? 16'(hb + r.payload) : 16'(r.tlen);
            etype = (r.kind == FK_ETHERTYPE) ? r.val[15:0] : ETHERTYPE_IPV4;
            dst = (r.kind == FK_DEST) ? r.val : own_addr;
            for (int i = 0; i < 12; i++)
                frame_bytes.push_back(8'($urandom));
            frame_bytes.push_back(etype[15:8]);
            frame_bytes.push_back(etype[7:0]);
            for (int i = 0; i < 60; i++)
                hdr[i] = 8'($urandom);
            hdr[0] = {(r.kind == FK_VERSION) ? r.val[3:0] : IP_VERSION_4, r.ihl};
            hdr[2] = tl16[15:8];
            hdr[3] = tl16[7:0];
            hdr[9] = (r.kind == FK_PROTO) ? r.val[7:0] : PROTO_ICMP;
            hdr[10] = 8'h00;
            hdr[11] = 8'h00;
            hdr[16] = dst[31:24];
            hdr[17] = dst[23:16];
            hdr[18] = dst[15:8];
            hdr[19] = dst[7:0];
            s = 0;
            for (int i = 0; i < hl; i++) begin
                s = s + ((i % 2 == 1) ? int'(hdr[i]) : (int'(hdr[i]) << 8));
                s = (s & 'hFFFF) + (s >> 16);
            end
            ck = ~16'(s);
            if (r.kind == FK_CHECKSUM)
                ck = ck ^ r.val[15:0];
            hdr[10] = ck[15:8];
            hdr[11] = ck[7:0];
            for (int i = 0; i < hb; i++)
                frame_bytes.push_back(hdr[i]);
            frame_bytes.push_back((r.kind == FK_ICMP_TYPE) ? r.val[7:0] : ICMP_ECHO_REPLY);
            for (int i = 1; i < r.payload; i++)
                frame_bytes.push_back(8'($urandom));
        end
        if (r.cut > 0)
            while (frame_bytes.size() > r.cut)
                void'(frame_bytes.pop_back());
    endtask

    task automatic send_byte(input logic [7:0] b, input logic last,
                             input logic known, input t_cause want);
        logic   done;
        t_cause cause;
        while ($urandom_range(99) < sender_idle_pct) begin
            push <= 1'b0;
            @(posedge i_clk);
        end
        push <= 1'b1;
        i_frame_byte <= b;
        i_last_byte <= last;
        @(posedge i_clk);
        while (full)
            @(posedge i_clk);
        bytes_sent++;
        absorb_byte(b, last, done, cause);
        if (done) begin
            if (known)
                cause = want;
            verdict_q.push_back(t_result'{accepted: (cause == CAUSE_OK), cause: cause});
        end
    endtask

    task automatic run_frame(input t_frame_row r);
        build_frame(r);
        for (int i = 0; i < frame_bytes.size(); i++)
            send_byte(frame_bytes[i], (i == frame_bytes.size() - 1), r.known, r.want);
        frames_sent++;
    endtask

    function automatic t_frame_row random_row();
        t_frame_row r;
        int pick;
        pick = $urandom_range(99);
        r.kind = FK_GOOD;
        r.ihl = ($urandom_range(99) < 60) ? 4'd5 : 4'($urandom_range(15, 5));
        r.payload = $urandom_range(24, 1);
        r.tlen = -1;
        r.cut = -1;
        r.val = $urandom;
        r.known = 1'b0;
        r.want = CAUSE_OK;
        if (pick < 40) begin
        end else if (pick < 45) begin
            r.ihl = 4'($urandom_range(4));
        end else if (pick < 50) begin
            case ($urandom_range(2))
                0: r.tlen = $urandom_range(65535);
                1: r.tlen = int'(r.ihl) * 4 - 1;
                default: r.tlen = int'(r.ihl) * 4 + r.payload + 1;
            endcase
        end else if (pick < 55) begin
            r.kind = FK_ETHERTYPE;
        end else if (pick < 60) begin
            r.kind = FK_VERSION;
        end else if (pick < 66) begin
            r.kind = FK_DEST;
            if ($urandom_range(1))
                r.val = own_addr ^ (32'd1 << $urandom_range(31));
        end else if (pick < 71) begin
            r.kind = FK_PROTO;
            r.val = $urandom_range(255);
        end else if (pick < 77) begin
            r.kind = FK_CHECKSUM;
            r.val = $urandom_range(65535, 1);
        end else if (pick < 83) begin
            r.kind = FK_ICMP_TYPE;
            r.val = $urandom_range(255, 1);
        end else if (pick < 88) begin
            // frame ends right where the icmp type byte would be
            r.tlen = int'(r.ihl) * 4;
            r.cut = 14 + int'(r.ihl) * 4;
        end else if (pick < 94) begin
            r.cut = $urandom_range(40, 1);
        end else begin
            r.kind = FK_NOISE;
            r.payload = $urandom_range(60, 1);
        end
        return r;
    endfunction

    task automatic settle_block();
        push <= 1'b0;
        while (verdict_q.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_local_address(input logic [31:0] addr);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= addr;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        own_addr = addr;
    endtask

    always @(posedge i_clk) begin : result_check
        t_result want_v;
        if (!i_rst_n) begin
            pop <= 1'b0;
        end else begin
            if (pop && !empty) begin
                verdicts_checked++;
                if (o_accepted === 1'b1)
                    frames_passed++;
                if (verdict_q.size() == 0) begin
                    mismatch_count++;
                    $display("%0t: unexpected verdict, expected none, ",
                             "actual accepted=%0b cause=%0d",
                             $time, o_accepted, o_reject_cause);
                end else begin
                    want_v = verdict_q.pop_front();
                    if (o_accepted !== want_v.accepted || o_reject_cause !== want_v.cause) begin
                        mismatch_count++;
                        $display("%0t: verdict mismatch, expected accepted=%0b cause=%0d, ",
                                 "actual accepted=%0b cause=%0d",
                                 $time, want_v.accepted, want_v.cause,
                                 o_accepted, o_reject_cause);
                    end
                end
            end
            pop <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    initial begin
        int ph_bytes0;
        int ph_frames0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        for (int ph = 0; ph < 4; ph++) begin
            if (ph > 0) begin
                settle_block();
                case (ph)
                    1: write_local_address(32'h0000_0000);
                    2: write_local_address(32'hFFFF_FFFF);
                    default: write_local_address($urandom);
                endcase
            end
            case (ph)
                0: begin sender_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin sender_idle_pct = 47; recv_stall_pct = 0;  end
                2: begin sender_idle_pct = 0;  recv_stall_pct = 47; end
                default: begin sender_idle_pct = 32; recv_stall_pct = 32; end
            endcase
            if (ph == 0)
                for (int i = 0; i < NUM_DIRECTED; i++)
                    run_frame(directed_rows[i]);
            ph_bytes0 = bytes_sent;
            ph_frames0 = frames_sent;
            while (bytes_sent - ph_bytes0 < PHASE_BYTES || frames_sent - ph_frames0 < PHASE_FRAMES)
                run_frame(random_row());
        end
        settle_block();
        if (verdict_q.size() != 0) begin
            mismatch_count++;
            $display("%0t: %0d verdicts never arrived", $time, verdict_q.size());
        end
        $display("frames sent: %0d (%0d bytes), verdicts checked: %0d, passed filter: %0d",
                 frames_sent, bytes_sent, verdicts_checked, frames_passed);
        $display("four local addresses and four idle/stall mixes, mismatches: %0d", mismatch_count);
        if (mismatch_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

/* files.f */
+incdir+rtl
rtl/ipv4f_pkg.sv
rtl/ipv4f_front.sv
rtl/ipv4f_rec_queue.sv
rtl/ipv4f_back.sv
rtl/ipv4_icmp_reply_frame_filter.sv
tb/sv/tb_ipv4_icmp_reply_frame_filter.sv
